// ===== hdl/fsrs_pkg.sv =====
// Shared types and constants of the free-run search allocator.
package fsrs_pkg;

  localparam int IDX_W    = 12;
  localparam int REQ_W    = 13;
  localparam int ADDR_W   = 16;
  localparam int USE_W    = 13;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 2;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 16;

  localparam logic OP_MARK   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_NEXT  = 2'd1;
  localparam logic [1:0] STRAT_BEST  = 2'd2;
  localparam logic [1:0] STRAT_WORST = 2'd3;

  localparam logic [CFG_IX_W-1:0] REG_STRATEGY = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_BASE     = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_USE_SIZE = 2'd2;

  localparam logic [USE_W-1:0] USE_SIZE_RESET = 13'd4096;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] cell_index;
    logic             cell_used;
    logic [REQ_W-1:0] request_size;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] offset;
  } res_t;

endpackage

// ===== hdl/fit_strategy_free_run_search.sv =====
// Top level of the free-run search allocator: registers, handshakes and result beat.
//
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | tuser op; tdata cell_index, cell_used, request_size
//  m_*     | out       | m_tvalid / m_tready    | tuser found; tdata address
//  cfg_*   | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// A search reads the cells in use (lim) in at most one pass for first, best and worst fit and
// in at most two passes for next fit; the single read port of the cell map reads one cell per
// cycle. After reset a clearing pass writes the map free with s_tready low.
// A result held on m_tready does not stop further beats; a second finished search holds
// s_tready low until the result beat is taken.
module fit_strategy_free_run_search
  import fsrs_pkg::*;
#(
  parameter int MAP_CELLS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // cell_index[11:0], cell_used[12], request_size[25:13]
  input  logic                s_tuser,  // op[0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // address[15:0]
  output logic                m_tuser,  // found[0]
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  logic [1:0]        strategy;
  logic [ADDR_W-1:0] base_address;
  logic [USE_W-1:0]  use_size;

  cmd_t cmd;
  res_t res;
  logic ready;
  logic res_valid;
  logic res_take;
  logic cmd_valid;

  assign cmd.op           = s_tuser;
  assign cmd.cell_index   = s_tdata[IDX_W-1:0];
  assign cmd.cell_used    = s_tdata[IDX_W];
  assign cmd.request_size = s_tdata[IDX_W+REQ_W:IDX_W+1];

  assign s_tready  = ready;
  assign cmd_valid = s_tvalid && ready;
  assign res_take  = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy     <= STRAT_FIRST;
      base_address <= '0;
      use_size     <= USE_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRATEGY: strategy     <= cfg_data[1:0];
        REG_BASE:     base_address <= cfg_data[ADDR_W-1:0];
        REG_USE_SIZE: use_size     <= cfg_data[USE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsrs_scan #(
    .MAP_CELLS (MAP_CELLS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .strategy  (strategy),
    .use_size  (use_size),
    .ready     (ready),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tuser <= res.found;
      m_tdata <= res.found ? M_DATA_W'(base_address + res.offset) : '0;
    end
  end

endmodule

// ===== hdl/fsrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsrs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fsrs_scan.sv =====
// Cell map store, clearing pass and run search sequencer.
module fsrs_scan
  import fsrs_pkg::*;
#(
  parameter int MAP_CELLS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  input  logic [1:0]       strategy,
  input  logic [USE_W-1:0] use_size,
  output logic             ready,
  output res_t             res,
  output logic             res_valid,
  input  logic             res_take
);

  localparam int AW = $clog2(MAP_CELLS);
  localparam int PW = $clog2(MAP_CELLS + 1);
  localparam int CW = (PW > REQ_W) ? PW : REQ_W;
  localparam int NW = CW + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [AW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic             dv;
  logic [AW-1:0]    dpos;
  logic [PW-1:0]    run_len;
  logic [AW-1:0]    run_start;
  logic             have;
  logic [PW-1:0]    pick_len;
  logic [AW-1:0]    pick_pos;
  logic [REQ_W-1:0] need;
  logic [1:0]       strat;
  logic             pass2;
  logic [PW-1:0]    lim;
  logic [AW-1:0]    next_start;
  logic             res_found;
  logic [AW-1:0]    res_pos;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_wdata;
  logic             mem_rdata;
  logic [PW-1:0]    lim_c;
  logic             issue;
  logic             free_cell;
  logic             used_cell;
  logic [PW-1:0]    len_inc;
  logic [AW-1:0]    start_eff;
  logic             extreme;
  logic             largest;
  logic             first_hit;
  logic             cand;
  logic             better;
  logic             pass_end;
  logic [NW-1:0]    nxt;
  logic             mark_ok;

  fsrs_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rp[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    lim_c = (32'(use_size) > 32'(MAP_CELLS)) ? PW'(MAP_CELLS) : PW'(use_size);
    mark_ok   = 32'(cmd.cell_index) < 32'(MAP_CELLS);
    mem_we    = (state == ST_CLEAR) ||
                ((state == ST_IDLE) && cmd_valid && (cmd.op == OP_MARK) && mark_ok);
    mem_waddr = (state == ST_CLEAR) ? wp : AW'(cmd.cell_index);
    mem_wdata = (state == ST_CLEAR) ? 1'b0 : cmd.cell_used;

    issue     = (state == ST_SCAN) && (rp < lim);
    free_cell = dv && !mem_rdata;
    used_cell = dv && mem_rdata;
    len_inc   = run_len + PW'(1);
    start_eff = (run_len == '0) ? dpos : run_start;
    extreme   = (strat == STRAT_BEST) || (strat == STRAT_WORST);
    largest   = (strat == STRAT_WORST);
    first_hit = !extreme && free_cell && (CW'(len_inc) == CW'(need));
    cand      = (CW'(run_len) >= CW'(need)) && (run_len != '0);
    better    = !have || (largest ? (run_len > pick_len) : (run_len < pick_len));
    pass_end  = (state == ST_SCAN) && !dv && (rp >= lim);
    nxt       = NW'(start_eff) + NW'(need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      wp         <= '0;
      dv         <= 1'b0;
      next_start <= '0;
    end else begin
      dv <= issue;
      unique case (state)
        ST_CLEAR: begin
          wp <= wp + AW'(1);
          if (32'(wp) == 32'(MAP_CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid && (cmd.op == OP_SEARCH)) begin
            need    <= cmd.request_size;
            strat   <= strategy;
            lim     <= lim_c;
            run_len <= '0;
            have    <= 1'b0;
            pass2   <= 1'b0;
            rp      <= (strategy == STRAT_NEXT) ? PW'(next_start) : '0;
            if (cmd.request_size == '0) begin
              res_found <= 1'b0;
              state     <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rp   <= rp + PW'(1);
            dpos <= rp[AW-1:0];
          end
          if (first_hit) begin
            res_found <= 1'b1;
            res_pos   <= start_eff;
            state     <= ST_DONE;
            if (strat == STRAT_NEXT) begin
              next_start <= (nxt >= NW'(lim)) ? '0 : nxt[AW-1:0];
            end
          end else if (free_cell) begin
            run_len   <= len_inc;
            run_start <= start_eff;
          end else if (used_cell) begin
            if (extreme && cand && better) begin
              have     <= 1'b1;
              pick_len <= run_len;
              pick_pos <= run_start;
            end
            run_len <= '0;
          end else if (pass_end) begin
            if (extreme) begin
              res_found <= have || cand;
              res_pos   <= (cand && better) ? run_start : pick_pos;
              state     <= ST_DONE;
            end else if ((strat == STRAT_NEXT) && !pass2) begin
              pass2   <= 1'b1;
              rp      <= '0;
              run_len <= '0;
            end else begin
              res_found <= 1'b0;
              state     <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready      = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);
  assign res.found  = res_found;
  assign res.offset = ADDR_W'(res_pos);

endmodule

// ===== hdl/fsrs_chk.sv =====
// Port-level checks of the free-run search allocator and their bind.
module fsrs_chk
  import fsrs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser,
  input logic                cfg_we,
  input logic [CFG_IX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]    cfg_data
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during clearing pass");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_SEARCH)) |=> !s_tready)
    else $error("new beat accepted while a search is in progress");

  a_mark_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_MARK) && !m_tvalid) |=> !m_tvalid)
    else $error("mark beat produced a result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed search reports a nonzero address");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind fit_strategy_free_run_search fsrs_chk u_chk (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the free-run search allocator: random and directed mark/search beats.
`timescale 1ns / 100ps

module testbench;
  import fsrs_pkg::*;

  localparam int HEAP_CELLS     = 4096;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 40000;

  localparam logic [CFG_IX_W-1:0] REG_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // cell_index[11:0], cell_used[12], request_size[25:13]
  logic                s_tuser = 1'b0;  // op[0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;  // address[15:0]
  logic                m_tuser;  // found[0]
  logic                cfg_we = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  fit_strategy_free_run_search #(.MAP_CELLS(HEAP_CELLS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // allocator shadow
  bit              heap_map [HEAP_CELLS];
  int              resume_pos = 0;
  logic [1:0]      strat_now = STRAT_FIRST;
  logic [15:0]     base_now = '0;
  logic [USE_W-1:0] use_now = USE_SIZE_RESET;

  cmd_t cmd_q [$];
  res_t grant_q [$];
  cmd_t cur_cmd;
  res_t want;
  bit   cmd_live = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   pressure_on = 1'b0;
  int   hold_cnt = 0;
  int   errors = 0;
  int   beats_in = 0;
  int   results = 0;
  int   phases = 0;
  int   quiet_cycles = 0;

  function automatic bit scan_first_fit(input int from, input int need, input int lim,
                                        output int pos);
    int cur;
    int len;
    int i;
    cur = from;
    pos = 0;
    while (cur < lim) begin
      if (!heap_map[cur]) begin
        len = 0;
        i = cur;
        while (i < lim && !heap_map[i] && len < need) begin
          len++;
          i++;
        end
        if (len == need) begin
          pos = cur;
          return 1'b1;
        end
        cur = i;
      end else begin
        cur++;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit scan_extreme_fit(input int need, input int lim, input bit largest,
                                          output int pos);
    int cur;
    int len;
    int i;
    int pick;
    bit have;
    cur = 0;
    pick = 0;
    have = 1'b0;
    pos = 0;
    while (cur < lim) begin
      if (!heap_map[cur]) begin
        len = 0;
        i = cur;
        while (i < lim && !heap_map[i]) begin
          len++;
          i++;
        end
        if (len >= need && (!have || (largest ? (len > pick) : (len < pick)))) begin
          have = 1'b1;
          pick = len;
          pos = cur;
        end
        cur = i;
      end else begin
        cur++;
      end
    end
    return have;
  endfunction

  function automatic void predict_grant(input cmd_t c);
    res_t r;
    int   lim;
    int   need;
    int   pos;
    int   nxt;
    bit   ok;
    if (c.op == OP_MARK) begin
      heap_map[c.cell_index] = c.cell_used;
      return;
    end
    need = int'(c.request_size);
    lim = (int'(use_now) > HEAP_CELLS) ? HEAP_CELLS : int'(use_now);
    pos = 0;
    ok = 1'b0;
    if (need != 0) begin
      case (strat_now)
        STRAT_FIRST: ok = scan_first_fit(0, need, lim, pos);
        STRAT_NEXT: begin
          ok = scan_first_fit(resume_pos, need, lim, pos);
          if (!ok) ok = scan_first_fit(0, need, lim, pos);
          if (ok) begin
            nxt = pos + need;
            resume_pos = (nxt >= lim) ? 0 : nxt;
          end
        end
        STRAT_BEST: ok = scan_extreme_fit(need, lim, 1'b0, pos);
        default: ok = scan_extreme_fit(need, lim, 1'b1, pos);
      endcase
    end
    r.found = ok;
    r.offset = ok ? ADDR_W'(int'(base_now) + pos) : '0;
    grant_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_grant(cur_cmd);
        beats_in++;
        cmd_live = 1'b0;
      end
      if (!cmd_live && cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        cmd_live = 1'b1;
        s_tdata <= S_DATA_W'({cur_cmd.request_size, cur_cmd.cell_used, cur_cmd.cell_index});
        s_tuser <= cur_cmd.op;
      end
      s_tvalid <= cmd_live;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found %0b address %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = grant_q.pop_front();
        results++;
        if (m_tuser !== want.found) begin
          errors++;
          $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, m_tuser);
        end
        if (m_tdata !== want.offset) begin
          errors++;
          $display("%0t: address mismatch, expected %h actual %h", $time, want.offset, m_tdata);
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v;
    case (ix)
      REG_STRATEGY: strat_now = v[1:0];
      REG_BASE:     base_now = v;
      REG_USE_SIZE: use_now = v[USE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || cmd_live || grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_mark(input int idx, input bit used);
    cmd_t c;
    c.op = OP_MARK;
    c.cell_index = idx[IDX_W-1:0];
    c.cell_used = used;
    c.request_size = REQ_W'($urandom);
    cmd_q.push_back(c);
  endtask

  task automatic queue_search(input int size);
    cmd_t c;
    c.op = OP_SEARCH;
    c.cell_index = IDX_W'($urandom);
    c.cell_used = 1'($urandom_range(0, 1));
    c.request_size = size[REQ_W-1:0];
    cmd_q.push_back(c);
  endtask

  task automatic random_phase(input logic [1:0] strat, input int use_cells, input int n,
                              input int send_pct, input int recv_pct, input logic [15:0] base);
    int k;
    int top;
    int roll;
    settle();
    write_reg(REG_STRATEGY, 16'(strat));
    write_reg(REG_USE_SIZE, 16'(use_cells));
    write_reg(REG_BASE, base);
    close_writes();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    top = (use_cells < 8) ? use_cells : use_cells / 4 + 1;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 55) begin
        queue_mark(($urandom_range(0, 9) == 0) ? $urandom_range(0, HEAP_CELLS - 1)
                                                : $urandom_range(0, use_cells - 1),
                   1'($urandom_range(0, 1)));
      end else begin
        roll = $urandom_range(0, 19);
        case (roll)
          0: queue_search(0);
          1: queue_search($urandom_range(HEAP_CELLS + 1, 8191));
          2: queue_search(HEAP_CELLS);
          default: queue_search($urandom_range(1, top));
        endcase
      end
    end
    phases++;
  endtask

  initial begin
    int m;
    int pct_s [4];
    int pct_r [4];
    pct_s = '{0, 81, 0, 14};
    pct_r = '{0, 0, 81, 14};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings, whole map free
    queue_search(1);
    queue_search(HEAP_CELLS);
    queue_search(0);
    queue_search(8191);
    settle();

    write_reg(REG_USE_SIZE, 16'd16);
    write_reg(REG_BASE, 16'hFFF8);
    write_reg(REG_STRATEGY, 16'(STRAT_FIRST));
    close_writes();
    queue_mark(3, 1'b1);
    queue_mark(8, 1'b1);
    queue_mark(9, 1'b1);
    queue_mark(12, 1'b1);
    queue_mark(HEAP_CELLS - 1, 1'b1);
    queue_mark(5, 1'b1);
    queue_mark(5, 1'b0);
    queue_search(3);
    queue_search(16);
    settle();

    write_reg(REG_STRATEGY, 16'(STRAT_WORST));
    close_writes();
    queue_search(3);
    queue_search(5);
    settle();

    write_reg(REG_STRATEGY, 16'(STRAT_BEST));
    close_writes();
    queue_search(3);
    queue_search(2);
    settle();

    write_reg(REG_STRATEGY, 16'(STRAT_NEXT));
    close_writes();
    repeat (4) queue_search(2);
    settle();

    // push the resume point high, then shrink the heap beneath it
    write_reg(REG_USE_SIZE, 16'd64);
    close_writes();
    queue_search(40);
    settle();
    write_reg(REG_USE_SIZE, 16'd16);
    close_writes();
    queue_search(2);
    settle();

    write_reg(REG_USE_SIZE, 16'd0);
    write_reg(REG_SPARE, 16'hA5C3);
    close_writes();
    queue_search(1);
    settle();
    write_reg(REG_USE_SIZE, 16'hFFFF);
    close_writes();
    queue_search(1);
    phases += 9;

    for (m = 0; m < 8; m++) begin
      random_phase(m[1:0], (m == 0) ? 1 : $urandom_range(8, 64), 12,
                   pct_s[m / 2], pct_r[m / 2],
                   (m % 4 == 1) ? 16'hFFFF : ((m % 4 == 3) ? 16'h0000 : 16'($urandom)));
    end
    random_phase(2'($urandom_range(0, 3)), HEAP_CELLS, 12, 0, 0, 16'($urandom));

    // long receiver hold-off with the sender flat out
    settle();
    write_reg(REG_STRATEGY, 16'(STRAT_FIRST));
    write_reg(REG_USE_SIZE, 16'd16);
    close_writes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_on = 1'b1;
    for (m = 0; m < 12; m++) queue_search($urandom_range(1, 4));
    phases++;

    settle();
    if (grant_q.size() != 0) begin
      errors += grant_q.size();
      $display("%0t: %0d expected results never arrived", $time, grant_q.size());
    end
    $display("Covered %0d phases: %0d input beats, %0d results checked, %0d errors",
             phases, beats_in, results, errors);
    $display("Strategies first/next/best/worst, heap sizes 0 to oversized, address wrap");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== fit_strategy_free_run_search.f =====
hdl/fsrs_pkg.sv
hdl/fsrs_ram.sv
hdl/fsrs_scan.sv
hdl/fit_strategy_free_run_search.sv
hdl/fsrs_chk.sv
bench/testbench.sv
